### hw/rtl/ovle_pkg.sv
// Package for the ordered value list engine: request and result item types,
// request kind and status codes, and the controller state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ovle_pkg;

  localparam logic [2:0] KIND_INS_FRONT = 3'd0;
  localparam logic [2:0] KIND_INS_BACK  = 3'd1;
  localparam logic [2:0] KIND_DELETE    = 3'd2;
  localparam logic [2:0] KIND_SEARCH    = 3'd3;
  localparam logic [2:0] KIND_CLEAR     = 3'd4;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_EMPTY     = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] position;
    logic [6:0] length;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_INSERT,
    ST_WALK,
    ST_FREE,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/ordered_value_list_engine.sv
// Top level of the ordered value list engine: linked list controller with
// value and link memories. Depends on ovle_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The engine keeps an ordered list of up to DEPTH signed 32-bit values as a
// linked list in two simple dual-port synchronous memories: one holds the
// values, the other holds each slot's link to the next slot.
//
// A request item is taken at a rising edge where start is high and busy is
// low. Exactly one result item follows: done is high for one cycle while the
// result port carries the status, the matched position and the new length.
// The receiver cannot stall; the result is simply presented for that cycle.
//
// Path from the accepting edge to the cycle with done high (ST_RESULT):
//   insert: ST_INSERT, after ST_ALLOC when the slot comes from the recycled free chain;
//   search: ST_WALK for each of the k entries visited (1..DEPTH);
//   delete: the walk as for search, then ST_FREE on a match;
//   clear, empty-list and full-list cases, unused kinds: ST_RESULT directly.
// The walk visits one entry per cycle, limited by the registered read of
// the link memory.
// busy drops in the cycle after done, when a new item may be started.
//
// Reset clears the length, the list pointers and the allocation counter. Slots
// are handed out fresh in order until all have been used once, and afterwards
// from a chain of freed slots, so the memories need no clearing pass.
module ordered_value_list_engine
  import ovle_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire req_t request,
  output logic      busy,
  output logic      done,
  output rsp_t      result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // List storage. Entries are always written before their read data is used.
  logic [31:0]   value_mem [DEPTH];
  logic [AW-1:0] link_mem  [DEPTH];

  logic [31:0]   value_rd;
  logic [AW-1:0] link_rd;
  logic [AW-1:0] rd_addr;

  logic          value_we;
  logic [AW-1:0] value_waddr;
  logic          link_we;
  logic [AW-1:0] link_waddr;
  logic [AW-1:0] link_wdata;

  // Control and list bookkeeping.
  state_t        state;
  state_t        state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] fresh;
  logic [AW-1:0] free_head;
  logic [AW-1:0] head;
  logic [AW-1:0] tail;

  // Per-request working registers.
  logic [2:0]    kind_q;
  logic [31:0]   value_q;
  logic [AW-1:0] slot;
  logic [AW-1:0] cur;
  logic [AW-1:0] prev;
  logic [AW-1:0] idx;
  logic [1:0]    res_status;
  logic [5:0]    res_pos;

  logic accept;
  logic is_insert;
  logic is_walk;
  logic list_full;
  logic list_empty;
  logic fresh_left;
  logic match;
  logic last_entry;

  assign accept     = start && (state == ST_IDLE);
  assign is_insert  = (request.kind == KIND_INS_FRONT) || (request.kind == KIND_INS_BACK);
  assign is_walk    = (request.kind == KIND_DELETE) || (request.kind == KIND_SEARCH);
  assign list_full  = (count == CW'(DEPTH));
  assign list_empty = (count == '0);
  assign fresh_left = (fresh != CW'(DEPTH));
  assign match      = (value_rd == value_q);
  assign last_entry = ((CW'(idx) + CW'(1)) == count);

  // The read address follows the list: the head or free-chain head when a
  // request starts, then the link just read while walking.
  always_comb begin
    if (state == ST_WALK) begin
      rd_addr = link_rd;
    end else if (is_insert) begin
      rd_addr = free_head;
    end else begin
      rd_addr = head;
    end
  end

  always_ff @(posedge clk) begin
    value_rd <= value_mem[rd_addr];
    link_rd  <= link_mem[rd_addr];
    if (value_we) begin
      value_mem[value_waddr] <= value_q;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
  end

  // Memory writes: new slot on insert, unlink and free-chain push on delete.
  always_comb begin
    value_we    = 1'b0;
    value_waddr = slot;
    link_we     = 1'b0;
    link_waddr  = slot;
    link_wdata  = head;
    case (state)
      ST_INSERT: begin
        value_we = 1'b1;
        if (!list_empty) begin
          link_we = 1'b1;
          if (kind_q == KIND_INS_FRONT) begin
            link_waddr = slot;
            link_wdata = head;
          end else begin
            link_waddr = tail;
            link_wdata = slot;
          end
        end
      end
      ST_WALK: begin
        if (match && (kind_q == KIND_DELETE) && (idx != '0)) begin
          link_we    = 1'b1;
          link_waddr = prev;
          link_wdata = link_rd;
        end
      end
      ST_FREE: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = free_head;
      end
      default: begin
        link_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (is_insert) begin
            if (list_full) begin
              state_next = ST_RESULT;
            end else if (fresh_left) begin
              state_next = ST_INSERT;
            end else begin
              state_next = ST_ALLOC;
            end
          end else if (is_walk) begin
            state_next = list_empty ? ST_RESULT : ST_WALK;
          end else begin
            state_next = ST_RESULT;
          end
        end
      end
      ST_ALLOC:  state_next = ST_INSERT;
      ST_INSERT: state_next = ST_RESULT;
      ST_WALK: begin
        if (match) begin
          state_next = (kind_q == KIND_DELETE) ? ST_FREE : ST_RESULT;
        end else if (last_entry) begin
          state_next = ST_RESULT;
        end
      end
      ST_FREE:   state_next = ST_RESULT;
      ST_RESULT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy            = (state != ST_IDLE);
    done            = (state == ST_RESULT);
    result.status   = res_status;
    result.position = res_pos;
    result.length   = 7'(count);
  end

  // List bookkeeping; these registers are control state and reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      fresh     <= '0;
      free_head <= '0;
      head      <= '0;
      tail      <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (is_insert && !list_full && fresh_left) begin
              fresh <= fresh + CW'(1);
            end else if (request.kind == KIND_CLEAR) begin
              count <= '0;
              fresh <= '0;
              head  <= '0;
              tail  <= '0;
            end
          end
        end
        ST_ALLOC: begin
          free_head <= link_rd;
        end
        ST_INSERT: begin
          count <= count + CW'(1);
          if (list_empty) begin
            head <= slot;
            tail <= slot;
          end else if (kind_q == KIND_INS_FRONT) begin
            head <= slot;
          end else begin
            tail <= slot;
          end
        end
        ST_WALK: begin
          if (match && (kind_q == KIND_DELETE)) begin
            if (idx == '0) begin
              head <= link_rd;
            end
            if (last_entry) begin
              tail <= (idx == '0) ? '0 : prev;
            end
          end
        end
        ST_FREE: begin
          free_head <= cur;
          count     <= count - CW'(1);
          if (count == CW'(1)) begin
            head <= '0;
            tail <= '0;
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // Working registers of the request in flight.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          kind_q     <= request.kind;
          value_q    <= request.item_value;
          res_pos    <= '0;
          slot       <= fresh[AW-1:0];
          cur        <= head;
          prev       <= '0;
          idx        <= '0;
          if (is_insert && list_full) begin
            res_status <= STATUS_FULL;
          end else if (is_walk && list_empty) begin
            res_status <= (request.kind == KIND_DELETE) ? STATUS_EMPTY : STATUS_NOT_FOUND;
          end else begin
            res_status <= STATUS_DONE;
          end
        end
      end
      ST_ALLOC: begin
        slot <= free_head;
      end
      ST_WALK: begin
        if (match) begin
          res_status <= STATUS_DONE;
          res_pos    <= 6'(idx);
        end else if (last_entry) begin
          res_status <= STATUS_NOT_FOUND;
        end else begin
          prev <= cur;
          cur  <= link_rd;
          idx  <= idx + AW'(1);
        end
      end
      default: begin
        res_pos <= res_pos;
      end
    endcase
  end

endmodule

`default_nettype wire
